// ===== sv/pulse_matched_filter_defines.svh =====
// Assertion macros shared by the pulse matched filter RTL.
`ifndef PULSE_MATCHED_FILTER_DEFINES_SVH
`define PULSE_MATCHED_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PMF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pmf_pkg.sv =====
// Package for the pulse matched filter: widths, codes, control structs, FSM type.
`timescale 1ns / 1ps
package pmf_pkg;

    localparam int DEF_MAX_TAPS     = 32;
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int OUT_WIDTH        = 40;
    localparam int CFG_WIDTH        = 6;
    localparam int TAP_IDX_WIDTH    = 5;

    localparam logic [CFG_WIDTH-1:0] TAPS_RESET = CFG_WIDTH'(32);

    // operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } t_state;

    // control to the sample cells
    typedef struct packed {
        logic push;
        logic shift;
        logic clear;
    } t_cell_ctl;

    // control to the multiply-accumulate unit
    typedef struct packed {
        logic issue;
        logic first;
        logic last;
        logic take;
    } t_mac_ctl;

endpackage

// ===== sv/pmf_if.sv =====
// Valid/ready channel interfaces for the sample input and the filter output.
`timescale 1ns / 1ps
interface pmf_smp_if #(
    parameter int SAMPLE_WIDTH = pmf_pkg::DEF_SAMPLE_WIDTH
) ();
    import pmf_pkg::*;

    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [TAP_IDX_WIDTH-1:0]       tap_index;
    logic signed [SAMPLE_WIDTH-1:0] sample_value;
    logic                           final_sample;

    modport source (
        output valid, operation, tap_index, sample_value, final_sample,
        input  ready
    );
    modport sink (
        input  valid, operation, tap_index, sample_value, final_sample,
        output ready
    );
endinterface

interface pmf_res_if ();
    import pmf_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] filtered_value;
    logic                        end_of_shot;

    modport source (
        output valid, filtered_value, end_of_shot,
        input  ready
    );
    modport sink (
        input  valid, filtered_value, end_of_shot,
        output ready
    );
endinterface

// ===== sv/pmf_cell.sv =====
// One cell of the sample chain: a history stage and a working copy that drains toward cell 0.
`timescale 1ns / 1ps
module pmf_cell #(
    parameter int SAMPLE_WIDTH = pmf_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pmf_pkg::t_cell_ctl             i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_hist,
    input  logic signed [SAMPLE_WIDTH-1:0] i_work,
    output logic signed [SAMPLE_WIDTH-1:0] o_hist,
    output logic signed [SAMPLE_WIDTH-1:0] o_work
);
    import pmf_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] r_hist;
    logic signed [SAMPLE_WIDTH-1:0] r_work;

    // history: shifts away from cell 0 on push, cleared at end of shot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_ctl.clear) begin
            r_hist <= '0;
        end else if (i_ctl.push) begin
            r_hist <= i_hist;
        end
    end

    // working copy: loaded with the new window, then walks toward cell 0
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_work <= i_hist;
        end else if (i_ctl.shift) begin
            r_work <= i_work;
        end
    end

    assign o_hist = r_hist;
    assign o_work = r_work;

endmodule

// ===== sv/pmf_mac.sv =====
// Tap memory and the pipelined multiply-accumulate that builds one output word.
`timescale 1ns / 1ps
`include "pulse_matched_filter_defines.svh"
module pmf_mac #(
    parameter int MAX_TAPS     = pmf_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_WIDTH = pmf_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pmf_pkg::t_mac_ctl                    i_ctl,
    input  logic                                 i_we,
    input  logic [$clog2(MAX_TAPS)-1:0]          i_waddr,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_wdata,
    input  logic [$clog2(MAX_TAPS)-1:0]          i_raddr,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_sample,
    output logic                                 o_done,
    output logic signed [pmf_pkg::OUT_WIDTH-1:0] o_acc
);
    import pmf_pkg::*;

    localparam int PW = 2 * SAMPLE_WIDTH;

    logic signed [SAMPLE_WIDTH-1:0] r_mem [MAX_TAPS];

    logic signed [SAMPLE_WIDTH-1:0] r_tap;
    logic signed [SAMPLE_WIDTH-1:0] r_xs;
    logic                           r_a_vld;
    logic                           r_a_first;
    logic                           r_a_last;

    logic signed [PW-1:0]           r_prod;
    logic                           r_b_vld;
    logic                           r_b_first;
    logic                           r_b_last;

    logic signed [OUT_WIDTH-1:0]    r_acc;
    logic                           r_done;
    logic signed [OUT_WIDTH-1:0]    w_prod_ext;

    // tap memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.issue) begin
            r_tap <= r_mem[i_raddr];
        end
    end

    // stage A: sample operand and step flags
    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_xs      <= i_sample;
            r_a_first <= i_ctl.first;
            r_a_last  <= i_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_ctl.issue;
            r_b_vld <= r_a_vld;
        end
    end

    // stage B: product
    always_ff @(posedge i_clk) begin
        if (r_a_vld) begin
            r_prod    <= r_tap * r_xs;
            r_b_first <= r_a_first;
            r_b_last  <= r_a_last;
        end
    end

    // stage C: accumulate, modulo the output width
    assign w_prod_ext = OUT_WIDTH'(r_prod);

    always_ff @(posedge i_clk) begin
        if (r_b_vld) begin
            r_acc <= (r_b_first ? '0 : r_acc) + w_prod_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else if (i_ctl.take) begin
            r_done <= 1'b0;
        end else if (r_b_vld && r_b_last) begin
            r_done <= 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

    // a held result never overlaps a new walk through the taps
    `PMF_ASSERT_IMPL(a_done_no_issue, r_done, !i_ctl.issue, "issue while result held")

endmodule

// ===== sv/pmf_ctrl.sv =====
// Sequencer: tap count register, input acceptance, tap walk and tail flush control.
`timescale 1ns / 1ps
`include "pulse_matched_filter_defines.svh"
module pmf_ctrl #(
    parameter int MAX_TAPS     = pmf_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_WIDTH = pmf_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pmf_pkg::CFG_WIDTH-1:0]        i_cfg_wdata,
    input  logic                                 i_in_valid,
    input  logic                                 i_operation,
    input  logic [pmf_pkg::TAP_IDX_WIDTH-1:0]    i_tap_index,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_sample,
    input  logic                                 i_final,
    input  logic                                 i_mac_done,
    input  logic                                 i_slot_free,
    output logic                                 o_in_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       o_head,
    output pmf_pkg::t_cell_ctl                   o_cell_ctl,
    output pmf_pkg::t_mac_ctl                    o_mac_ctl,
    output logic                                 o_tap_we,
    output logic [$clog2(MAX_TAPS)-1:0]          o_tap_waddr,
    output logic [$clog2(MAX_TAPS)-1:0]          o_tap_raddr,
    output logic                                 o_eos
);
    import pmf_pkg::*;

    localparam int AW = $clog2(MAX_TAPS);
    localparam int CW = $clog2(MAX_TAPS + 1);
    localparam logic [7:0]    MaxTapsW = 8'(MAX_TAPS);
    localparam logic [CW-1:0] MaxTapsC = CW'(MAX_TAPS);
    localparam logic [CW-1:0] OneC     = CW'(1);

    t_state                 r_state, n_state;
    logic [AW-1:0]          r_step, n_step;
    logic [CW-1:0]          r_len, n_len;
    logic [AW-1:0]          r_tail_left, n_tail_left;
    logic                   r_final, n_final;
    logic [CFG_WIDTH-1:0]   r_taps, n_taps;

    logic [CW-1:0]          w_len_act;
    logic                   w_sample_acc;
    logic                   w_load_acc;
    logic                   w_take;
    logic                   w_run_last;
    logic                   w_tail_more;

    // tap count clipped to 1..MAX_TAPS
    always_comb begin
        if (r_taps == '0) begin
            w_len_act = OneC;
        end else if (8'(r_taps) > MaxTapsW) begin
            w_len_act = MaxTapsC;
        end else begin
            w_len_act = CW'(r_taps);
        end
    end

    assign w_sample_acc = i_in_valid && (r_state == ST_IDLE) && (i_operation == OP_SAMPLE);
    assign w_load_acc   = i_in_valid && (r_state == ST_IDLE) && (i_operation == OP_LOAD);
    assign w_run_last   = (CW'(r_step) == (r_len - OneC));
    assign w_take       = (r_state == ST_WAIT) && i_mac_done && i_slot_free;
    assign w_tail_more  = (r_tail_left != '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_sample_acc) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_run_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_take) begin
                    n_state = w_tail_more ? ST_RUN : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // counters and per-shot registers
    always_comb begin
        n_step      = (r_state == ST_RUN && !w_run_last) ? r_step + AW'(1) : '0;
        n_len       = w_sample_acc ? w_len_act : r_len;
        n_final     = w_sample_acc ? i_final : r_final;
        n_taps      = i_cfg_we ? i_cfg_wdata : r_taps;
        n_tail_left = r_tail_left;
        if (w_sample_acc) begin
            n_tail_left = i_final ? AW'(w_len_act - OneC) : '0;
        end else if (w_take && w_tail_more) begin
            n_tail_left = r_tail_left - AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_len       <= OneC;
            r_tail_left <= '0;
            r_final     <= 1'b0;
            r_taps      <= TAPS_RESET;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_len       <= n_len;
            r_tail_left <= n_tail_left;
            r_final     <= n_final;
            r_taps      <= n_taps;
        end
    end

    // outputs
    always_comb begin
        o_in_ready       = (r_state == ST_IDLE);
        // tail pushes feed zeros into the history
        o_head           = (r_state == ST_IDLE) ? i_sample : '0;
        o_cell_ctl.push  = w_sample_acc || (w_take && w_tail_more);
        o_cell_ctl.shift = (r_state == ST_RUN);
        o_cell_ctl.clear = w_take && !w_tail_more && r_final;
        o_mac_ctl.issue  = (r_state == ST_RUN);
        o_mac_ctl.first  = (r_state == ST_RUN) && (r_step == '0);
        o_mac_ctl.last   = (r_state == ST_RUN) && w_run_last;
        o_mac_ctl.take   = w_take;
        o_tap_we         = w_load_acc && (8'(i_tap_index) < MaxTapsW);
        o_tap_waddr      = AW'(i_tap_index);
        // pulse is applied time reversed: step s uses tap L-1-s
        o_tap_raddr      = AW'(r_len - OneC - CW'(r_step));
        o_eos            = r_final && !w_tail_more;
    end

    `PMF_ASSERT_IMPL(a_step_in_range, r_state == ST_RUN, CW'(r_step) < r_len, "step beyond tap count")
    `PMF_ASSERT_IMPL(a_tail_bound, r_state != ST_IDLE, CW'(r_tail_left) < r_len, "tail count too large")
    `PMF_ASSERT_NEXT(a_take_then_free, w_take && !w_tail_more, r_state == ST_IDLE, "no return to idle")

endmodule

// ===== sv/pulse_matched_filter.sv =====
// Top level of the pulse matched filter: sample cell chain, MAC unit, sequencer, output register.
//
//   channel   dir  handshake          word
//   i_smp     in   valid/ready        operation, tap_index, sample_value, final_sample
//   o_res     out  valid/ready        filtered_value, end_of_shot
//   i_cfg_*   in   write enable only  taps_in_use
//
// A sample yields one result, and a final sample yields L-1 more tail outputs (L = tap count):
// one shared multiply-accumulate walks the taps, one tap per cycle, behind a three-stage pipe.
// Reset is synchronous: history cleared, tap count back to 32, tap memory left as is.
// A full output register holds the sequencer in its wait state; new words are taken
// while a finished result still waits at the output.
`timescale 1ns / 1ps
module pulse_matched_filter #(
    parameter int MAX_TAPS     = pmf_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_WIDTH = pmf_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pmf_pkg::CFG_WIDTH-1:0] i_cfg_wdata,
    pmf_smp_if.sink                       i_smp,
    pmf_res_if.source                     o_res
);
    import pmf_pkg::*;

    localparam int AW = $clog2(MAX_TAPS);

    t_cell_ctl                      w_cell_ctl;
    t_mac_ctl                       w_mac_ctl;
    logic                           w_in_ready;
    logic signed [SAMPLE_WIDTH-1:0] w_head;
    logic                           w_tap_we;
    logic [AW-1:0]                  w_tap_waddr;
    logic [AW-1:0]                  w_tap_raddr;
    logic                           w_eos;
    logic                           w_mac_done;
    logic signed [OUT_WIDTH-1:0]    w_mac_acc;
    logic                           w_slot_free;

    logic signed [SAMPLE_WIDTH-1:0] w_hin  [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] w_wout [MAX_TAPS];

    logic                           r_out_vld;
    logic signed [OUT_WIDTH-1:0]    r_out_val;
    logic                           r_out_eos;

    assign w_slot_free = !r_out_vld || o_res.ready;

    pmf_ctrl #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_smp.valid),
        .i_operation (i_smp.operation),
        .i_tap_index (i_smp.tap_index),
        .i_sample    (i_smp.sample_value),
        .i_final     (i_smp.final_sample),
        .i_mac_done  (w_mac_done),
        .i_slot_free (w_slot_free),
        .o_in_ready  (w_in_ready),
        .o_head      (w_head),
        .o_cell_ctl  (w_cell_ctl),
        .o_mac_ctl   (w_mac_ctl),
        .o_tap_we    (w_tap_we),
        .o_tap_waddr (w_tap_waddr),
        .o_tap_raddr (w_tap_raddr),
        .o_eos       (w_eos)
    );

    assign i_smp.ready = w_in_ready;

    // sample chain: history moves away from cell 0, working copy drains into it
    assign w_hin[0] = w_head;

    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        if (k < MAX_TAPS - 1) begin : g_mid
            pmf_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_cell_ctl),
                .i_hist  (w_hin[k]),
                .i_work  (w_wout[k+1]),
                .o_hist  (w_hin[k+1]),
                .o_work  (w_wout[k])
            );
        end else begin : g_end
            pmf_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_cell_ctl),
                .i_hist  (w_hin[k]),
                .i_work  ('0),
                .o_hist  (),
                .o_work  (w_wout[k])
            );
        end
    end

    pmf_mac #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_we     (w_tap_we),
        .i_waddr  (w_tap_waddr),
        .i_wdata  (i_smp.sample_value),
        .i_raddr  (w_tap_raddr),
        .i_sample (w_wout[0]),
        .o_done   (w_mac_done),
        .o_acc    (w_mac_acc)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_mac_ctl.take) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mac_ctl.take) begin
            r_out_val <= w_mac_acc;
            r_out_eos <= w_eos;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.filtered_value = r_out_val;
    assign o_res.end_of_shot    = r_out_eos;

endmodule
